/* hw/rtl/fopc_pkg.sv */
// shared types and constants of the fixed-offset packet classifier
`default_nettype none

package fopc_pkg;

  // snippet staging geometry
  localparam int unsigned SNIPPET_BYTES  = 64;
  localparam int unsigned PAYLOAD_OFFSET = 54;
  localparam int unsigned SNIP_AW        = $clog2(SNIPPET_BYTES);

  // byte positions of the header fields
  localparam logic [15:0] POS_ETYPE_HI = 16'd12;
  localparam logic [15:0] POS_ETYPE_LO = 16'd13;
  localparam logic [15:0] POS_PROTO    = 16'd23;
  localparam logic [15:0] POS_SPORT_HI = 16'd34;
  localparam logic [15:0] POS_SPORT_LO = 16'd35;
  localparam logic [15:0] POS_DPORT_HI = 16'd36;
  localparam logic [15:0] POS_DPORT_LO = 16'd37;
  localparam logic [15:0] POS_MAX      = 16'hFFFF;

  localparam logic [15:0] STAGE_LO = 16'(PAYLOAD_OFFSET);
  localparam logic [15:0] STAGE_HI = 16'(PAYLOAD_OFFSET + SNIPPET_BYTES);

  localparam logic [15:0] ETH_HDR_LEN     = 16'd14;
  localparam logic [15:0] MIN_DPORT_LEN   = 16'd38;
  localparam logic [15:0] CAPTURE_MIN_LEN = STAGE_HI;

  localparam logic [15:0] ETH_IPV4  = 16'h0800;
  localparam logic [7:0]  PROTO_TCP = 8'd6;

  // configuration register indexes
  localparam logic [1:0] REG_COUNT_PORT_A = 2'd0;
  localparam logic [1:0] REG_COUNT_PORT_B = 2'd1;
  localparam logic [1:0] REG_CAPTURE_PORT = 2'd2;

  // result kinds
  localparam logic KIND_REPORT  = 1'b0;
  localparam logic KIND_SNIPPET = 1'b1;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] pass_length;
    logic [63:0] hits_port_a;
    logic [63:0] hits_port_b;
    logic        captured;
    logic [5:0]  snippet_index;
    logic [7:0]  snippet_byte;
    logic        run_last;
  } out_word_t;

  typedef struct packed {
    logic [15:0] count_port_a;
    logic [15:0] count_port_b;
    logic [15:0] capture_port;
  } cfg_t;

  typedef struct packed {
    logic [15:0] pass_length;
    logic [63:0] hits_port_a;
    logic [63:0] hits_port_b;
    logic        captured;
  } report_t;

  typedef struct packed {
    logic               en;
    logic [SNIP_AW-1:0] addr;
    logic [7:0]         data;
  } stage_wr_t;

  typedef struct packed {
    logic busy;
    logic can_load;
  } snip_status_t;

endpackage

`default_nettype wire

/* hw/rtl/fopc_parse.sv */
// header field latching, frame qualification and hit counters
`default_nettype none

module fopc_parse import fopc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  in_word_t  word,
  input  cfg_t      cfg,
  output logic      report_valid,
  output report_t   report,
  output stage_wr_t stage_wr
);

  logic [15:0] byte_position;
  logic [15:0] ether_type;
  logic [7:0]  ip_protocol;
  logic [15:0] source_port;
  logic [15:0] dst_port;
  logic [63:0] count_a;
  logic [63:0] count_b;

  logic [15:0] ether_type_next;
  logic [7:0]  ip_protocol_next;
  logic [15:0] source_port_next;
  logic [15:0] dst_port_next;
  logic [63:0] count_a_next;
  logic [63:0] count_b_next;
  logic [15:0] pos_inc;
  logic        tcp4;
  logic        count_ok;

  always_comb begin
    ether_type_next  = ether_type;
    ip_protocol_next = ip_protocol;
    source_port_next = source_port;
    dst_port_next    = dst_port;
    unique case (byte_position)
      POS_ETYPE_HI: ether_type_next  = {word.frame_byte, ether_type[7:0]};
      POS_ETYPE_LO: ether_type_next  = {ether_type[15:8], word.frame_byte};
      POS_PROTO:    ip_protocol_next = word.frame_byte;
      POS_SPORT_HI: source_port_next = {word.frame_byte, source_port[7:0]};
      POS_SPORT_LO: source_port_next = {source_port[15:8], word.frame_byte};
      POS_DPORT_HI: dst_port_next    = {word.frame_byte, dst_port[7:0]};
      POS_DPORT_LO: dst_port_next    = {dst_port[15:8], word.frame_byte};
      default: ;
    endcase

    // saturating position, also the frame length on the last byte
    pos_inc  = (byte_position == POS_MAX) ? byte_position : byte_position + 16'd1;
    tcp4     = (ether_type_next == ETH_IPV4) && (ip_protocol_next == PROTO_TCP);
    count_ok = tcp4 && (pos_inc >= MIN_DPORT_LEN);

    count_a_next = (count_ok && dst_port_next == cfg.count_port_a) ? count_a + 64'd1 : count_a;
    count_b_next = (count_ok && dst_port_next == cfg.count_port_b) ? count_b + 64'd1 : count_b;

    report.pass_length = (pos_inc < ETH_HDR_LEN) ? 16'd0 : pos_inc;
    report.hits_port_a = count_a_next;
    report.hits_port_b = count_b_next;
    report.captured    = tcp4 && (pos_inc >= CAPTURE_MIN_LEN) &&
                         (source_port_next == cfg.capture_port ||
                          dst_port_next == cfg.capture_port);

    stage_wr.en   = accept && (byte_position >= STAGE_LO) && (byte_position < STAGE_HI);
    stage_wr.addr = SNIP_AW'(byte_position - STAGE_LO);
    stage_wr.data = word.frame_byte;
  end

  assign report_valid = accept && word.frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      ether_type    <= '0;
      ip_protocol   <= '0;
      source_port   <= '0;
      dst_port      <= '0;
      count_a       <= '0;
      count_b       <= '0;
    end else if (accept) begin
      ether_type  <= ether_type_next;
      ip_protocol <= ip_protocol_next;
      source_port <= source_port_next;
      dst_port    <= dst_port_next;
      if (word.frame_end) begin
        byte_position <= '0;
        count_a       <= count_a_next;
        count_b       <= count_b_next;
      end else begin
        byte_position <= pos_inc;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/fopc_snippet.sv */
// payload staging memory, snippet sequencer and two-stage result pipe
`default_nettype none

module fopc_snippet import fopc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  stage_wr_t    stage_wr,
  input  logic         report_valid,
  input  report_t      report,
  output snip_status_t status,
  output logic         result_valid,
  input  logic         result_stall,
  output out_word_t    result
);

  localparam logic [SNIP_AW-1:0] LAST_INDEX = SNIP_AW'(SNIPPET_BYTES - 1);

  logic [7:0] stage_mem [SNIPPET_BYTES];
  logic [7:0] mem_q;

  logic               busy;
  logic [SNIP_AW-1:0] seq_index;
  report_t            run_report;

  logic      a_valid;
  out_word_t a_word;
  out_word_t a_word_next;
  out_word_t b_word_next;

  logic               b_free;
  logic               a_can_load;
  logic               a_load;
  logic               a_load_seq;
  logic [SNIP_AW-1:0] rd_addr;

  assign b_free     = !result_valid || !result_stall;
  assign a_can_load = !a_valid || b_free;
  assign a_load_seq = busy && a_can_load;
  assign a_load     = report_valid || a_load_seq;
  assign rd_addr    = a_load_seq ? seq_index : '0;

  assign status.busy     = busy;
  assign status.can_load = a_can_load;

  always_comb begin
    if (a_load_seq) begin
      a_word_next.kind          = KIND_SNIPPET;
      a_word_next.pass_length   = run_report.pass_length;
      a_word_next.hits_port_a   = run_report.hits_port_a;
      a_word_next.hits_port_b   = run_report.hits_port_b;
      a_word_next.captured      = 1'b1;
      a_word_next.snippet_index = 6'(seq_index);
      a_word_next.run_last      = (seq_index == LAST_INDEX);
    end else begin
      a_word_next.kind          = KIND_REPORT;
      a_word_next.pass_length   = report.pass_length;
      a_word_next.hits_port_a   = report.hits_port_a;
      a_word_next.hits_port_b   = report.hits_port_b;
      a_word_next.captured      = report.captured;
      a_word_next.snippet_index = '0;
      a_word_next.run_last      = !report.captured || (SNIPPET_BYTES == 1);
    end
    // filled from the memory read when moving to the output stage
    a_word_next.snippet_byte = '0;
  end

  always_comb begin
    b_word_next              = a_word;
    b_word_next.snippet_byte = a_word.captured ? mem_q : 8'd0;
  end

  // staging memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (stage_wr.en) begin
      stage_mem[stage_wr.addr] <= stage_wr.data;
    end
    if (a_load) begin
      mem_q <= stage_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      seq_index    <= '0;
      a_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (report_valid && report.captured && SNIPPET_BYTES > 1) begin
        busy      <= 1'b1;
        seq_index <= SNIP_AW'(1);
      end else if (a_load_seq) begin
        seq_index <= seq_index + SNIP_AW'(1);
        if (seq_index == LAST_INDEX) begin
          busy <= 1'b0;
        end
      end

      if (a_load) begin
        a_valid <= 1'b1;
      end else if (b_free) begin
        a_valid <= 1'b0;
      end

      if (a_valid && b_free) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (report_valid) begin
      run_report <= report;
    end
    if (a_load) begin
      a_word <= a_word_next;
    end
    if (a_valid && b_free) begin
      result <= b_word_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/fixed_offset_packet_classifier.sv */
// top level of the fixed-offset packet header classifier
`default_nettype none

// Ethernet frame bytes enter one word per cycle on the frame channel, with
// frame_end on the last byte. Header fields are picked out at fixed byte
// positions and payload bytes 54 to 117 are written into a 64-entry staging
// memory. Mid-frame bytes are taken every cycle while no snippet is read out,
// even while a result waits on the result channel. The last byte of a frame
// yields a report word through the stage register (beside the memory read),
// then the result register. When the frame qualifies for capture the report
// carries snippet byte 0 and is followed by 63 snippet words, one per cycle
// unless the result channel stalls, read through the single read port of
// the staging memory; the frame channel is stalled while they are read out.
// A frame end is also stalled while both result stages are full. Registers on
// the cfg channel are always ready; write them only while the block is idle.

module fixed_offset_packet_classifier import fopc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // frame byte channel
  input  logic        frame_valid,
  output logic        frame_stall,
  input  in_word_t    frame,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output out_word_t   result,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t         cfg;
  logic         frame_accept;
  logic         report_valid;
  report_t      report;
  stage_wr_t    stage_wr;
  snip_status_t status;

  // configuration registers, writes beyond the list fall through
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.count_port_a <= 16'd22;
      cfg.count_port_b <= 16'd443;
      cfg.capture_port <= 16'd8080;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_COUNT_PORT_A: cfg.count_port_a <= cfg_data;
        REG_COUNT_PORT_B: cfg.count_port_b <= cfg_data;
        REG_CAPTURE_PORT: cfg.capture_port <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold input while a snippet drains, or when a frame end has nowhere to go
  assign frame_stall  = status.busy || (frame.frame_end && !status.can_load);
  assign frame_accept = frame_valid && !frame_stall;

  fopc_parse u_parse (
    .clk          (clk),
    .rst          (rst),
    .accept       (frame_accept),
    .word         (frame),
    .cfg          (cfg),
    .report_valid (report_valid),
    .report       (report),
    .stage_wr     (stage_wr)
  );

  fopc_snippet u_snippet (
    .clk          (clk),
    .rst          (rst),
    .stage_wr     (stage_wr),
    .report_valid (report_valid),
    .report       (report),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // a report without capture closes its run and carries no snippet byte
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == KIND_REPORT && !result.captured) |->
      (result.run_last && result.snippet_byte == 8'd0))
    else $error("uncaptured report not closed");

  // snippet words only belong to captured frames
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == KIND_SNIPPET) |->
      (result.captured && result.snippet_index != 6'd0))
    else $error("snippet word outside a capture");

  // the last snippet word closes the run
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == KIND_SNIPPET &&
     result.snippet_index == 6'(SNIPPET_BYTES - 1)) |-> result.run_last)
    else $error("snippet run not closed");

  // no frame byte gets in while a snippet is still being read out
  assert property (@(posedge clk) disable iff (rst)
    status.busy |-> !frame_accept && !stage_wr.en)
    else $error("staging memory written during snippet readout");

endmodule

`default_nettype wire

/* verif/fixed_offset_packet_classifier_test.sv */
// self-checking testbench of the fixed-offset packet header classifier
`timescale 1ns / 100ps

module fixed_offset_packet_classifier_test;
  import fopc_pkg::*;

  // no register sits at this index, writes to it must change nothing
  localparam logic [1:0] REG_UNUSED = 2'd3;
  // quiet cycles before the run is declared hung: covers the long result
  // hold-off, a full snippet burst and the longest idle bursts on both sides
  localparam int unsigned QUIET_LIMIT  = 2000;
  // cycles to let pass once no word is awaited, well above the latency of the result pipe
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam logic [15:0] ETYPE_IPV6    = 16'h86DD;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;

  logic        clk;
  logic        rst;
  logic        frame_valid;
  logic        frame_stall;
  in_word_t    frame;
  logic        result_valid;
  logic        result_stall;
  out_word_t   result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  fixed_offset_packet_classifier DUT (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame        (frame),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 20 ns clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // classifier shadow: header fields, staged payload, hit counters, registers
  // ---------------------------------------------------------------------------
  logic [15:0] frame_pos;
  logic [15:0] seen_etype;
  logic [7:0]  seen_proto;
  logic [15:0] seen_sport;
  logic [15:0] seen_dport;
  logic [7:0]  staged_payload [SNIPPET_BYTES];
  logic [63:0] hits_a;
  logic [63:0] hits_b;
  cfg_t        port_regs;

  // result words still to come out of the block, oldest first
  out_word_t   awaited_words [$];
  int unsigned mismatches;

  // bytes of the frame being built, in wire order
  logic [7:0]  frame_buf [$];

  // idling controls of the frame driver and the stall process
  bit          tx_idling;
  bit          rx_idling;
  int unsigned hold_len;

  function automatic void clear_shadow();
    frame_pos  = '0;
    seen_etype = '0;
    seen_proto = '0;
    seen_sport = '0;
    seen_dport = '0;
    hits_a     = '0;
    hits_b     = '0;
    port_regs.count_port_a = 16'd22;
    port_regs.count_port_b = 16'd443;
    port_regs.capture_port = 16'd8080;
    for (int i = 0; i < SNIPPET_BYTES; i++) staged_payload[i] = '0;
  endfunction

  // follow one accepted frame byte; on the last byte work out the report and
  // any snippet words, and queue them
  function automatic void classify_byte(in_word_t w);
    logic [16:0] len;
    logic [15:0] plen;
    logic        tcp4;
    logic        grab;
    out_word_t   o;
    case (frame_pos)
      POS_ETYPE_HI: seen_etype[15:8] = w.frame_byte;
      POS_ETYPE_LO: seen_etype[7:0]  = w.frame_byte;
      POS_PROTO:    seen_proto       = w.frame_byte;
      POS_SPORT_HI: seen_sport[15:8] = w.frame_byte;
      POS_SPORT_LO: seen_sport[7:0]  = w.frame_byte;
      POS_DPORT_HI: seen_dport[15:8] = w.frame_byte;
      POS_DPORT_LO: seen_dport[7:0]  = w.frame_byte;
      default: ;
    endcase
    if (frame_pos >= STAGE_LO && frame_pos < STAGE_HI)
      staged_payload[SNIP_AW'(frame_pos - STAGE_LO)] = w.frame_byte;
    if (!w.frame_end) begin
      // position sticks at the top for very long frames
      if (frame_pos != POS_MAX) frame_pos = frame_pos + 16'd1;
      return;
    end
    len = {1'b0, frame_pos} + 17'd1;
    if (len > {1'b0, POS_MAX}) len = {1'b0, POS_MAX};
    frame_pos = '0;
    plen = (len < {1'b0, ETH_HDR_LEN}) ? 16'd0 : len[15:0];
    tcp4 = (seen_etype == ETH_IPV4) && (seen_proto == PROTO_TCP);
    if (tcp4 && len >= {1'b0, MIN_DPORT_LEN}) begin
      // both counters move when the two registers hold the same port
      if (seen_dport == port_regs.count_port_a) hits_a = hits_a + 64'd1;
      if (seen_dport == port_regs.count_port_b) hits_b = hits_b + 64'd1;
    end
    grab = tcp4 && len >= {1'b0, CAPTURE_MIN_LEN} &&
           (seen_sport == port_regs.capture_port || seen_dport == port_regs.capture_port);
    o = '0;
    o.kind        = KIND_REPORT;
    o.pass_length = plen;
    o.hits_port_a = hits_a;
    o.hits_port_b = hits_b;
    o.run_last    = 1'b1;
    if (!grab) begin
      awaited_words.push_back(o);
      return;
    end
    // report carries snippet byte 0, snippet words carry the rest
    for (int i = 0; i < SNIPPET_BYTES; i++) begin
      o.kind          = (i == 0) ? KIND_REPORT : KIND_SNIPPET;
      o.captured      = 1'b1;
      o.snippet_index = SNIP_AW'(i);
      o.snippet_byte  = staged_payload[i];
      o.run_last      = (i == SNIPPET_BYTES - 1);
      awaited_words.push_back(o);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  out_word_t oldest_word;

  function automatic void check_field(string name, logic [63:0] expected, logic [63:0] actual);
    if (actual !== expected) begin
      $error("%s: expected %0h, got %0h", name, expected, actual);
      mismatches++;
    end
  endfunction

  // every accepted result word is held against the oldest awaited word
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (awaited_words.size() == 0) begin
        $error("result word with nothing awaited: %0h", result);
        mismatches++;
      end else begin
        oldest_word = awaited_words.pop_front();
        check_field("kind",          oldest_word.kind,          result.kind);
        check_field("pass_length",   oldest_word.pass_length,   result.pass_length);
        check_field("hits_port_a",   oldest_word.hits_port_a,   result.hits_port_a);
        check_field("hits_port_b",   oldest_word.hits_port_b,   result.hits_port_b);
        check_field("captured",      oldest_word.captured,      result.captured);
        check_field("snippet_index", oldest_word.snippet_index, result.snippet_index);
        check_field("snippet_byte",  oldest_word.snippet_byte,  result.snippet_byte);
        check_field("run_last",      oldest_word.run_last,      result.run_last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side stall: random bursts, or one long hold-off when asked
  // ---------------------------------------------------------------------------
  initial begin
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        result_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
        result_stall <= 1'b0;
      end else if (rx_idling && $urandom_range(0, 7) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long without any word or register write moving ends the run
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles;

  always @(posedge clk) begin
    if (rst || (frame_valid && !frame_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // driving helpers
  // ---------------------------------------------------------------------------

  // offer one frame byte, with an occasional idle burst first; valid is left
  // high afterwards so back-to-back bytes need no extra edge
  task automatic send_word(logic [7:0] b, logic last);
    in_word_t w;
    w.frame_byte = b;
    w.frame_end  = last;
    if (tx_idling && $urandom_range(0, 7) == 0) begin
      frame_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    frame_valid <= 1'b1;
    frame       <= w;
    do @(posedge clk); while (frame_stall);
    classify_byte(w);
  endtask

  task automatic send_frame();
    int unsigned n;
    n = frame_buf.size();
    for (int unsigned i = 0; i < n; i++) send_word(frame_buf[i], i == n - 1);
  endtask

  // random bytes with the header fields placed at their fixed positions
  function automatic void build_frame(int unsigned len, logic [15:0] etype, logic [7:0] proto,
                                      logic [15:0] sport, logic [15:0] dport);
    logic [7:0] b;
    frame_buf.delete();
    for (int unsigned i = 0; i < len; i++) begin
      b = 8'($urandom);
      case (16'(i))
        POS_ETYPE_HI: b = etype[15:8];
        POS_ETYPE_LO: b = etype[7:0];
        POS_PROTO:    b = proto;
        POS_SPORT_HI: b = sport[15:8];
        POS_SPORT_LO: b = sport[7:0];
        POS_DPORT_HI: b = dport[15:8];
        POS_DPORT_LO: b = dport[7:0];
        default: ;
      endcase
      frame_buf.push_back(b);
    end
  endfunction

  task automatic tcp_frame(int unsigned len, logic [15:0] sport, logic [15:0] dport);
    build_frame(len, ETH_IPV4, PROTO_TCP, sport, dport);
    send_frame();
  endtask

  // lower valid, wait for every awaited word, then let the pipe settle
  task automatic drain();
    frame_valid <= 1'b0;
    @(posedge clk);
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_COUNT_PORT_A: port_regs.count_port_a = val;
      REG_COUNT_PORT_B: port_regs.count_port_b = val;
      REG_CAPTURE_PORT: port_regs.capture_port = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one random frame: mostly IPv4/TCP aimed at the programmed ports, the rest
  // foreign ethertypes, other protocols and runts
  task automatic random_frame();
    int unsigned len;
    int unsigned pick;
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [15:0] sport;
    logic [15:0] dport;
    pick = $urandom_range(0, 19);
    if (pick < 7)       len = $urandom_range(CAPTURE_MIN_LEN, CAPTURE_MIN_LEN + 32);
    else if (pick < 16) len = $urandom_range(MIN_DPORT_LEN, CAPTURE_MIN_LEN - 1);
    else                len = $urandom_range(1, MIN_DPORT_LEN - 1);
    etype = ($urandom_range(0, 9) == 0) ? 16'($urandom) : ETH_IPV4;
    proto = ($urandom_range(0, 9) == 0) ? 8'($urandom) : PROTO_TCP;
    case ($urandom_range(0, 3))
      0: dport = port_regs.count_port_a;
      1: dport = port_regs.count_port_b;
      2: dport = port_regs.capture_port;
      default: dport = 16'($urandom);
    endcase
    sport = $urandom_range(0, 1) ? port_regs.capture_port : 16'($urandom);
    build_frame(len, etype, proto, sport, dport);
    send_frame();
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // ports as they come out of reset: 22 and 443 counted, 8080 captured
  task automatic test_reset_ports();
    tcp_frame(MIN_DPORT_LEN, 16'($urandom), 16'd22);
    tcp_frame(60, 16'($urandom), 16'd443);
    tcp_frame(CAPTURE_MIN_LEN, 16'd8080, 16'd1);
  endtask

  // runts: no pass length below the ethernet header, no count below the port
  task automatic test_short_frames();
    tcp_frame(1, 16'd0, 16'd0);
    tcp_frame(ETH_HDR_LEN - 1, 16'd0, 16'd0);
    tcp_frame(ETH_HDR_LEN, 16'd0, 16'd0);
    tcp_frame(MIN_DPORT_LEN - 1, 16'd80, 16'd22);
  endtask

  // each qualifying condition missed once, then met
  task automatic test_qualification();
    build_frame(64, ETYPE_IPV6, PROTO_TCP, 16'd8080, 16'd22);
    send_frame();
    build_frame(64, ETH_IPV4, PROTO_UDP, 16'd8080, 16'd22);
    send_frame();
    tcp_frame(CAPTURE_MIN_LEN - 1, 16'd5, 16'd8080);
    tcp_frame(CAPTURE_MIN_LEN, 16'd5, 16'd8080);
    // same port in both count registers bumps both counters
    drain();
    write_reg(REG_COUNT_PORT_A, 16'd1234);
    write_reg(REG_COUNT_PORT_B, 16'd1234);
    tcp_frame(40, 16'd9, 16'd1234);
    // a write to the empty index leaves every register alone
    drain();
    write_reg(REG_UNUSED, 16'hFFFF);
    tcp_frame(40, 16'd9, 16'd1234);
  endtask

  // lowest port value in count register A, highest in B, both in the capture register
  task automatic test_port_extremes();
    drain();
    write_reg(REG_COUNT_PORT_A, 16'h0000);
    write_reg(REG_COUNT_PORT_B, 16'hFFFF);
    write_reg(REG_CAPTURE_PORT, 16'h0000);
    tcp_frame(120, 16'd77, 16'h0000);
    tcp_frame(CAPTURE_MIN_LEN, 16'h0000, 16'hFFFF);
    drain();
    write_reg(REG_CAPTURE_PORT, 16'hFFFF);
    tcp_frame(130, 16'hFFFF, 16'd7);
  endtask

  // frame longer than the position counter: pass length sticks at the top
  task automatic test_long_frame();
    tx_idling = 1'b0;
    tcp_frame(66000, port_regs.capture_port, port_regs.count_port_a);
    tx_idling = 1'b1;
  endtask

  // receiver holds off while frames keep coming, so the block fills and
  // stalls frame ends; mid-frame bytes must still be taken
  task automatic test_backpressure();
    drain();
    hold_len = HOLD_CYCLES;
    tcp_frame(CAPTURE_MIN_LEN, port_regs.capture_port, 16'd3);
    tcp_frame(40, 16'd3, port_regs.count_port_b);
    tcp_frame(CAPTURE_MIN_LEN + 5, 16'd4, port_regs.capture_port);
    tcp_frame(40, 16'd3, port_regs.count_port_a);
    tcp_frame(CAPTURE_MIN_LEN, port_regs.capture_port, 16'd3);
  endtask

  // random frames over several register settings
  task automatic test_random_frames();
    for (int phase = 0; phase < 3; phase++) begin
      drain();
      write_reg(REG_COUNT_PORT_A, 16'($urandom));
      write_reg(REG_COUNT_PORT_B, 16'($urandom));
      write_reg(REG_CAPTURE_PORT, 16'($urandom));
      if ($urandom_range(0, 1)) write_reg(REG_UNUSED, 16'($urandom));
      repeat (20) random_frame();
    end
  endtask

  // closing stretch at full rate on both sides
  task automatic test_full_rate();
    drain();
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    repeat (15) random_frame();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst         = 1'b1;
    frame_valid = 1'b0;
    frame       = '0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    tx_idling   = 1'b1;
    rx_idling   = 1'b1;
    hold_len    = 0;
    mismatches  = 0;
    clear_shadow();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_ports();
    test_short_frames();
    test_qualification();
    test_port_extremes();
    test_long_frame();
    test_backpressure();
    test_random_frames();
    test_full_rate();
    drain();

    if (awaited_words.size() != 0)
      $error("%0d result words never arrived", awaited_words.size());
    if (mismatches == 0 && awaited_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
